### rtl/kri_pkg.sv
package kri_pkg;

  localparam int MAX_KEYS  = 8;
  localparam int KEY_IDX_W = $clog2(MAX_KEYS);
  localparam int KEY_CNT_W = $clog2(MAX_KEYS + 1);

  localparam int TIME_W = 16;
  localparam int VAL_W  = 16;
  localparam int PIC_W  = 2;
  localparam int COEF_W = 17;
  localparam int NUM_FIELDS = 4;
  localparam int FLD_W = 2;

  localparam logic [TIME_W-1:0] TIME_MAX = '1;
  localparam logic [COEF_W-1:0] COEF_ONE = COEF_W'(65536);

  typedef enum logic [1:0] {
    KIND_APPEND = 2'd0,
    KIND_START  = 2'd1,
    KIND_TICK   = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD,
    ST_CMP,
    ST_COEF,
    ST_DIV,
    ST_MUL,
    ST_ACC,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic [TIME_W-1:0] t;
    logic [VAL_W-1:0]  x;
    logic [VAL_W-1:0]  y;
    logic [VAL_W-1:0]  w;
    logic [VAL_W-1:0]  h;
    logic [PIC_W-1:0]  pic;
  } key_ent_t;

  typedef struct packed {
    logic              start;
    logic [TIME_W-1:0] num;
    logic [TIME_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [TIME_W-1:0] quo;
  } div_rsp_t;

  function automatic logic [VAL_W-1:0] field_of(key_ent_t e, logic [FLD_W-1:0] f);
    logic [VAL_W-1:0] v;
    case (f)
      2'd0:    v = e.x;
      2'd1:    v = e.y;
      2'd2:    v = e.w;
      default: v = e.h;
    endcase
    return v;
  endfunction

endpackage

### rtl/kri_div.sv
module kri_div (
  input  logic              clk,
  input  logic              rst_n,
  input  kri_pkg::div_req_t req,
  output kri_pkg::div_rsp_t rsp
);
  import kri_pkg::*;

  localparam int CNT_W = $clog2(TIME_W + 1);

  logic [TIME_W-1:0] rem_r, rem_nxt;
  logic [TIME_W-1:0] quo_r, quo_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [TIME_W:0]   shifted;
  logic [TIME_W:0]   diff;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
  end

  always_comb begin
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    shifted  = {rem_r, 1'b0};
    diff     = shifted - {1'b0, req.den};
    if (req.start) begin
      rem_nxt  = req.num;
      quo_nxt  = '0;
      cnt_nxt  = CNT_W'(TIME_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!diff[TIME_W]) begin
        rem_nxt = diff[TIME_W-1:0];
        quo_nxt = {quo_r[TIME_W-2:0], 1'b1};
      end else begin
        rem_nxt = shifted[TIME_W-1:0];
        quo_nxt = {quo_r[TIME_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  assign rsp.done = done_r;
  assign rsp.quo  = quo_r;

endmodule

### rtl/keyframe_rect_interpolator_top.sv
// channel | valid     | stall     | payload
// in      | in_valid  | in_stall  | in_kind, in_clear_first, in_key_*, in_delta_time
// out     | out_valid | out_stall | out_frame_valid, out_x, out_y, out_width,
//         |           |           | out_height, out_picture
// Append, start and unknown words never stall the input. A tick stalls it while the
// keys are scanned (one table read port), the coefficient is formed, the serial
// divider runs, each field is blended (shared multiplier) and the result is placed.
// rst_n is synchronous; it clears the key count, the clocks and the run flag.
// in_stall is high while a tick is at work and while its result cannot be
// placed because the output register still holds an untaken word.
module keyframe_rect_interpolator_top (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [1:0]                  in_kind,
  input  logic                        in_clear_first,
  input  logic [kri_pkg::TIME_W-1:0]  in_key_time,
  input  logic [kri_pkg::VAL_W-1:0]   in_key_x,
  input  logic [kri_pkg::VAL_W-1:0]   in_key_y,
  input  logic [kri_pkg::VAL_W-1:0]   in_key_width,
  input  logic [kri_pkg::VAL_W-1:0]   in_key_height,
  input  logic [kri_pkg::PIC_W-1:0]   in_key_picture,
  input  logic [kri_pkg::TIME_W-1:0]  in_delta_time,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        out_frame_valid,
  output logic [kri_pkg::VAL_W-1:0]   out_x,
  output logic [kri_pkg::VAL_W-1:0]   out_y,
  output logic [kri_pkg::VAL_W-1:0]   out_width,
  output logic [kri_pkg::VAL_W-1:0]   out_height,
  output logic [kri_pkg::PIC_W-1:0]   out_picture
);
  import kri_pkg::*;

  key_ent_t mem [MAX_KEYS];
  key_ent_t mem_q;
  logic                 mem_we;
  logic [KEY_IDX_W-1:0] mem_waddr;
  key_ent_t             mem_wdata;

  state_t               state_r, state_nxt;
  logic [KEY_CNT_W-1:0] count_r, count_nxt;
  logic                 running_r, running_nxt;
  logic [TIME_W-1:0]    now_r, now_nxt;
  logic [TIME_W-1:0]    prev_r, prev_nxt;
  logic [TIME_W-1:0]    used_r, used_nxt;
  logic [KEY_IDX_W-1:0] scan_r, scan_nxt;
  key_ent_t             lo_r, lo_nxt;
  key_ent_t             hi_r, hi_nxt;
  logic [COEF_W-1:0]    coef_r, coef_nxt;
  logic [FLD_W-1:0]     fld_r, fld_nxt;
  logic [31:0]          prod_r, prod_nxt;
  logic                 fv_r, fv_nxt;
  logic [VAL_W-1:0]     res_r [NUM_FIELDS];
  logic                 res_we;
  logic [VAL_W-1:0]     res_val;

  logic                 ov_r, ov_nxt;
  logic                 ofv_r, ofv_nxt;
  logic [VAL_W-1:0]     ox_r, ox_nxt, oy_r, oy_nxt, ow_r, ow_nxt, oh_r, oh_nxt;
  logic [PIC_W-1:0]     op_r, op_nxt;

  logic [KEY_CNT_W-1:0] count_eff;
  logic [TIME_W:0]      sum;
  logic [TIME_W-1:0]    sat;
  logic [VAL_W-1:0]     v1, v2;
  logic signed [VAL_W:0]    diff;
  logic signed [COEF_W+VAL_W:0] prod_full;

  div_req_t div_req;
  div_rsp_t div_rsp;

  kri_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    mem_q <= mem[scan_r];
    if (res_we) begin
      res_r[fld_r] <= res_val;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      count_r   <= '0;
      running_r <= 1'b0;
      now_r     <= '0;
      prev_r    <= '0;
      ov_r      <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      count_r   <= count_nxt;
      running_r <= running_nxt;
      now_r     <= now_nxt;
      prev_r    <= prev_nxt;
      ov_r      <= ov_nxt;
    end
    used_r <= used_nxt;
    scan_r <= scan_nxt;
    lo_r   <= lo_nxt;
    hi_r   <= hi_nxt;
    coef_r <= coef_nxt;
    fld_r  <= fld_nxt;
    prod_r <= prod_nxt;
    fv_r   <= fv_nxt;
    ofv_r  <= ofv_nxt;
    ox_r   <= ox_nxt;
    oy_r   <= oy_nxt;
    ow_r   <= ow_nxt;
    oh_r   <= oh_nxt;
    op_r   <= op_nxt;
  end

  assign v1 = field_of(lo_r, fld_r);
  assign v2 = field_of(hi_r, fld_r);
  assign diff = $signed({1'b0, v2}) - $signed({1'b0, v1});
  assign prod_full = diff * $signed({1'b0, coef_r});
  assign sum = {1'b0, now_r} + {1'b0, in_delta_time};
  assign sat = sum[TIME_W] ? TIME_MAX : sum[TIME_W-1:0];
  assign count_eff = in_clear_first ? '0 : count_r;

  always_comb begin
    state_nxt   = state_r;
    count_nxt   = count_r;
    running_nxt = running_r;
    now_nxt     = now_r;
    prev_nxt    = prev_r;
    used_nxt    = used_r;
    scan_nxt    = scan_r;
    lo_nxt      = lo_r;
    hi_nxt      = hi_r;
    coef_nxt    = coef_r;
    fld_nxt     = fld_r;
    prod_nxt    = prod_r;
    fv_nxt      = fv_r;
    res_we      = 1'b0;
    res_val     = v1 + prod_r[31:16];
    mem_we      = 1'b0;
    mem_waddr   = count_eff[KEY_IDX_W-1:0];
    mem_wdata   = '{t: in_key_time, x: in_key_x, y: in_key_y, w: in_key_width,
                    h: in_key_height, pic: in_key_picture};
    div_req     = '{start: 1'b0, num: used_r - lo_r.t, den: hi_r.t - lo_r.t};
    ov_nxt      = ov_r & out_stall;
    ofv_nxt     = ofv_r;
    ox_nxt      = ox_r;
    oy_nxt      = oy_r;
    ow_nxt      = ow_r;
    oh_nxt      = oh_r;
    op_nxt      = op_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          case (in_kind)
            KIND_APPEND: begin
              count_nxt = count_eff;
              if (count_eff < KEY_CNT_W'(MAX_KEYS)) begin
                mem_we    = 1'b1;
                count_nxt = count_eff + 1'b1;
              end
            end
            KIND_START: begin
              running_nxt = 1'b1;
              now_nxt     = '0;
              prev_nxt    = '0;
            end
            KIND_TICK: begin
              fv_nxt    = 1'b0;
              state_nxt = ST_FIN;
              if (running_r) begin
                prev_nxt = now_r;
                now_nxt  = sat;
                used_nxt = sat;
                scan_nxt = '0;
                if (count_r == '0 || (count_r == KEY_CNT_W'(1) && now_r != '0)) begin
                  running_nxt = 1'b0;
                end else begin
                  state_nxt = ST_RD;
                end
              end
            end
            default: ;
          endcase
        end
      end
      ST_RD: begin
        state_nxt = ST_CMP;
      end
      ST_CMP: begin
        hi_nxt = mem_q;
        lo_nxt = (scan_r == '0) ? mem_q : hi_r;
        if (mem_q.t >= used_r) begin
          state_nxt = ST_COEF;
        end else if (KEY_CNT_W'(scan_r) == KEY_CNT_W'(count_r - 1'b1)) begin
          if (mem_q.t < prev_r) begin
            running_nxt = 1'b0;
            fv_nxt      = 1'b0;
            state_nxt   = ST_FIN;
          end else begin
            used_nxt  = mem_q.t;
            state_nxt = ST_COEF;
          end
        end else begin
          scan_nxt  = scan_r + 1'b1;
          state_nxt = ST_RD;
        end
      end
      ST_COEF: begin
        fld_nxt   = '0;
        coef_nxt  = '0;
        state_nxt = ST_MUL;
        if (hi_r.t > lo_r.t) begin
          if (used_r <= lo_r.t) begin
            coef_nxt = '0;
          end else if (used_r >= hi_r.t) begin
            coef_nxt = COEF_ONE;
          end else begin
            div_req.start = 1'b1;
            state_nxt     = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        if (div_rsp.done) begin
          coef_nxt  = {1'b0, div_rsp.quo};
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        prod_nxt  = prod_full[31:0];
        state_nxt = ST_ACC;
      end
      ST_ACC: begin
        res_we = 1'b1;
        if (fld_r == FLD_W'(NUM_FIELDS - 1)) begin
          fv_nxt    = 1'b1;
          state_nxt = ST_FIN;
        end else begin
          fld_nxt   = fld_r + 1'b1;
          state_nxt = ST_MUL;
        end
      end
      ST_FIN: begin
        if (!ov_r || !out_stall) begin
          ov_nxt    = 1'b1;
          ofv_nxt   = fv_r;
          ox_nxt    = fv_r ? res_r[0] : '0;
          oy_nxt    = fv_r ? res_r[1] : '0;
          ow_nxt    = fv_r ? res_r[2] : '0;
          oh_nxt    = fv_r ? res_r[3] : '0;
          op_nxt    = fv_r ? hi_r.pic : '0;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign in_stall        = (state_r != ST_IDLE);
  assign out_valid       = ov_r;
  assign out_frame_valid = ofv_r;
  assign out_x           = ox_r;
  assign out_y           = oy_r;
  assign out_width       = ow_r;
  assign out_height      = oh_r;
  assign out_picture     = op_r;

endmodule

### bench/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import kri_pkg::*;

  localparam logic [1:0] KIND_UNKNOWN = 2'd3;
  localparam int unsigned CYCLE_LIMIT = 500000;
  localparam int unsigned DRAIN_CYCLES = 80;
  localparam int unsigned RANDOM_WORDS = 600;
  localparam int unsigned HOLD_CYCLES = 700;

  typedef struct packed {
    logic [1:0]        kind;
    logic              clear_first;
    logic [TIME_W-1:0] t;
    logic [VAL_W-1:0]  x;
    logic [VAL_W-1:0]  y;
    logic [VAL_W-1:0]  w;
    logic [VAL_W-1:0]  h;
    logic [PIC_W-1:0]  pic;
    logic [TIME_W-1:0] delta;
  } anim_word_t;

  typedef struct packed {
    logic             fv;
    logic [VAL_W-1:0] x;
    logic [VAL_W-1:0] y;
    logic [VAL_W-1:0] w;
    logic [VAL_W-1:0] h;
    logic [PIC_W-1:0] pic;
  } frame_t;

  typedef enum {RX_FREE, RX_LIGHT, RX_HEAVY, RX_PULSE} rx_mode_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [1:0]        in_kind = '0;
  logic              in_clear_first = 1'b0;
  logic [TIME_W-1:0] in_key_time = '0;
  logic [VAL_W-1:0]  in_key_x = '0;
  logic [VAL_W-1:0]  in_key_y = '0;
  logic [VAL_W-1:0]  in_key_width = '0;
  logic [VAL_W-1:0]  in_key_height = '0;
  logic [PIC_W-1:0]  in_key_picture = '0;
  logic [TIME_W-1:0] in_delta_time = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic              out_frame_valid;
  logic [VAL_W-1:0]  out_x;
  logic [VAL_W-1:0]  out_y;
  logic [VAL_W-1:0]  out_width;
  logic [VAL_W-1:0]  out_height;
  logic [PIC_W-1:0]  out_picture;

  anim_word_t pending_words[$];
  frame_t     expected_frames[$];
  int unsigned total_words;
  int unsigned words_taken = 0;
  int unsigned mismatch_count = 0;
  int unsigned cycle_count = 0;

  logic [TIME_W-1:0] tbl_time [MAX_KEYS];
  logic [VAL_W-1:0]  tbl_x [MAX_KEYS];
  logic [VAL_W-1:0]  tbl_y [MAX_KEYS];
  logic [VAL_W-1:0]  tbl_w [MAX_KEYS];
  logic [VAL_W-1:0]  tbl_h [MAX_KEYS];
  logic [PIC_W-1:0]  tbl_pic [MAX_KEYS];
  int                keys_loaded = 0;
  bit                anim_running = 1'b0;
  logic [TIME_W-1:0] now_t = '0;
  logic [TIME_W-1:0] prev_t = '0;

  keyframe_rect_interpolator_top i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_kind         (in_kind),
    .in_clear_first  (in_clear_first),
    .in_key_time     (in_key_time),
    .in_key_x        (in_key_x),
    .in_key_y        (in_key_y),
    .in_key_width    (in_key_width),
    .in_key_height   (in_key_height),
    .in_key_picture  (in_key_picture),
    .in_delta_time   (in_delta_time),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_frame_valid (out_frame_valid),
    .out_x           (out_x),
    .out_y           (out_y),
    .out_width       (out_width),
    .out_height      (out_height),
    .out_picture     (out_picture)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [VAL_W-1:0] lerp_field(logic [VAL_W-1:0] a, logic [VAL_W-1:0] b,
                                                  logic [COEF_W-1:0] c);
    logic [63:0] acc;
    acc = 64'(a) * (64'(COEF_ONE) - 64'(c)) + 64'(b) * 64'(c);
    return acc[VAL_W+15:16];
  endfunction

  function automatic frame_t blend_frame(logic [TIME_W-1:0] delta);
    frame_t            f;
    logic [TIME_W:0]   sum;
    logic [TIME_W-1:0] used;
    logic [TIME_W-1:0] t1;
    logic [TIME_W-1:0] t2;
    logic [COEF_W-1:0] c;
    logic [63:0]       num;
    int                i;
    int                k1;
    int                k2;
    bit                found;
    f = '0;
    if (!anim_running) return f;
    prev_t = now_t;
    sum = now_t + delta;
    now_t = sum[TIME_W] ? TIME_MAX : sum[TIME_W-1:0];
    if (keys_loaded == 0) begin
      anim_running = 1'b0;
      return f;
    end
    if (keys_loaded == 1) begin
      if (prev_t != 0) begin
        anim_running = 1'b0;
        return f;
      end
      f = {1'b1, tbl_x[0], tbl_y[0], tbl_w[0], tbl_h[0], tbl_pic[0]};
      return f;
    end
    used = now_t;
    found = 1'b0;
    k2 = 0;
    for (i = 0; i < keys_loaded; i++) begin
      if (!found && tbl_time[i] >= used) begin
        k2 = i;
        found = 1'b1;
      end
    end
    if (!found) begin
      k2 = keys_loaded - 1;
      if (tbl_time[k2] < prev_t) begin
        anim_running = 1'b0;
        return f;
      end
      used = tbl_time[k2];
    end
    k1 = (k2 > 0) ? k2 - 1 : 0;
    t1 = tbl_time[k1];
    t2 = tbl_time[k2];
    c = '0;
    if (t2 > t1) begin
      if (used <= t1) begin
        c = '0;
      end else if (used >= t2) begin
        c = COEF_ONE;
      end else begin
        num = 64'(used - t1) << 16;
        c = COEF_W'(num / 64'(t2 - t1));
      end
    end
    f.fv = 1'b1;
    f.x = lerp_field(tbl_x[k1], tbl_x[k2], c);
    f.y = lerp_field(tbl_y[k1], tbl_y[k2], c);
    f.w = lerp_field(tbl_w[k1], tbl_w[k2], c);
    f.h = lerp_field(tbl_h[k1], tbl_h[k2], c);
    f.pic = tbl_pic[k2];
    return f;
  endfunction

  function automatic anim_word_t noise_word();
    anim_word_t wd;
    wd.kind = 2'($urandom_range(0, 3));
    wd.clear_first = 1'($urandom_range(0, 1));
    wd.t = TIME_W'($urandom);
    wd.x = VAL_W'($urandom);
    wd.y = VAL_W'($urandom);
    wd.w = VAL_W'($urandom);
    wd.h = VAL_W'($urandom);
    wd.pic = PIC_W'($urandom);
    wd.delta = TIME_W'($urandom);
    return wd;
  endfunction

  task automatic queue_key(input logic clr, input logic [TIME_W-1:0] t,
                           input logic [VAL_W-1:0] x, input logic [VAL_W-1:0] y,
                           input logic [VAL_W-1:0] w, input logic [VAL_W-1:0] h,
                           input logic [PIC_W-1:0] pic);
    anim_word_t wd;
    wd = noise_word();
    wd.kind = KIND_APPEND;
    wd.clear_first = clr;
    wd.t = t;
    wd.x = x;
    wd.y = y;
    wd.w = w;
    wd.h = h;
    wd.pic = pic;
    pending_words.push_back(wd);
  endtask

  task automatic queue_ctl(input logic [1:0] kind, input logic [TIME_W-1:0] delta);
    anim_word_t wd;
    wd = noise_word();
    wd.kind = kind;
    wd.delta = delta;
    pending_words.push_back(wd);
  endtask

  task automatic check_field(input string name, input logic [VAL_W-1:0] want,
                             input logic [VAL_W-1:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, actual %0h", name, want, got);
      mismatch_count++;
    end
  endtask

  // sender: bursts and gaps; predict on every accepted word
  anim_word_t offered;
  int unsigned burst_left = 0;
  int unsigned gap_left = 0;

  always @(posedge clk) begin
    if (in_valid && !in_stall) begin
      words_taken++;
      case (offered.kind)
        KIND_APPEND: begin
          if (offered.clear_first) keys_loaded = 0;
          if (keys_loaded < MAX_KEYS) begin
            tbl_time[keys_loaded] = offered.t;
            tbl_x[keys_loaded] = offered.x;
            tbl_y[keys_loaded] = offered.y;
            tbl_w[keys_loaded] = offered.w;
            tbl_h[keys_loaded] = offered.h;
            tbl_pic[keys_loaded] = offered.pic;
            keys_loaded++;
          end
        end
        KIND_START: begin
          anim_running = 1'b1;
          now_t = '0;
          prev_t = '0;
        end
        KIND_TICK: expected_frames.push_back(blend_frame(offered.delta));
        default: ;
      endcase
    end
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (pending_words.size() > 0) begin
        offered = pending_words.pop_front();
        in_kind <= offered.kind;
        in_clear_first <= offered.clear_first;
        in_key_time <= offered.t;
        in_key_x <= offered.x;
        in_key_y <= offered.y;
        in_key_width <= offered.w;
        in_key_height <= offered.h;
        in_key_picture <= offered.pic;
        in_delta_time <= offered.delta;
        in_valid <= 1'b1;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(0, 24);
          gap_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 6);
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver: stall pattern, plus a long hold-off now and then
  int unsigned rx_cycle = 0;
  int unsigned hold_left = 0;
  int unsigned mode_left = 0;
  rx_mode_t    rx_mode = RX_FREE;

  always @(posedge clk) begin
    rx_cycle++;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (rx_cycle % 12000 == 2000) begin
      hold_left = HOLD_CYCLES;
      out_stall <= 1'b1;
    end else begin
      if (mode_left == 0) begin
        rx_mode = rx_mode_t'($urandom_range(0, 3));
        mode_left = $urandom_range(30, 200);
      end else begin
        mode_left--;
      end
      case (rx_mode)
        RX_FREE:  out_stall <= 1'b0;
        RX_LIGHT: out_stall <= ($urandom_range(0, 7) == 0);
        RX_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
        default:  out_stall <= rx_cycle[3];
      endcase
    end
  end

  frame_t due;

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_frames.size() == 0) begin
        $error("result word with none expected");
        mismatch_count++;
      end else begin
        due = expected_frames.pop_front();
        check_field("frame_valid", VAL_W'(due.fv), VAL_W'(out_frame_valid));
        check_field("x", due.x, out_x);
        check_field("y", due.y, out_y);
        check_field("width", due.w, out_width);
        check_field("height", due.h, out_height);
        check_field("picture", VAL_W'(due.pic), VAL_W'(out_picture));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("testbench failed");
      $finish;
    end
  end

  initial begin
    int          r;
    int          nkeys;
    int          nticks;
    int          tt;
    int          avg;
    int          d;
    bit          clr;

    queue_ctl(KIND_TICK, 16'h0010);
    queue_ctl(KIND_START, '0);
    queue_ctl(KIND_TICK, 16'h0100);
    queue_key(1'b1, 16'h0100, '1, '0, '1, '0, 2'd3);
    queue_ctl(KIND_START, '1);
    queue_ctl(KIND_TICK, 16'h0080);
    queue_ctl(KIND_TICK, 16'h0080);
    queue_key(1'b1, '0, '1, '1, '1, '1, 2'd3);
    queue_key(1'b0, '1, '0, '0, '0, '0, 2'd0);
    queue_ctl(KIND_START, '0);
    queue_ctl(KIND_TICK, 16'h8000);
    queue_ctl(KIND_TICK, '1);
    queue_ctl(KIND_TICK, '1);
    queue_ctl(KIND_UNKNOWN, '1);
    queue_key(1'b1, 16'h0100, VAL_W'($urandom), VAL_W'($urandom), VAL_W'($urandom),
              VAL_W'($urandom), 2'd1);
    queue_key(1'b0, 16'h0100, VAL_W'($urandom), VAL_W'($urandom), VAL_W'($urandom),
              VAL_W'($urandom), 2'd2);
    queue_ctl(KIND_START, TIME_W'($urandom));
    queue_ctl(KIND_TICK, 16'h0400);
    queue_key(1'b1, 16'h0300, VAL_W'($urandom), VAL_W'($urandom), VAL_W'($urandom),
              VAL_W'($urandom), 2'd0);
    queue_key(1'b0, 16'h0100, VAL_W'($urandom), VAL_W'($urandom), VAL_W'($urandom),
              VAL_W'($urandom), 2'd3);
    queue_ctl(KIND_START, TIME_W'($urandom));
    queue_ctl(KIND_TICK, 16'h0400);
    queue_ctl(KIND_TICK, 16'h0100);

    while (pending_words.size() < 23 + RANDOM_WORDS) begin
      if ($urandom_range(0, 9) < 8) begin
        r = $urandom_range(0, 19);
        if (r == 0) nkeys = 0;
        else if (r == 1) nkeys = 1;
        else if (r <= 3) nkeys = $urandom_range(9, 11);
        else nkeys = $urandom_range(2, 8);
        tt = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 16'hF000) : $urandom_range(0, 16'h0100);
        for (int k = 0; k < nkeys; k++) begin
          if ($urandom_range(0, 9) == 0) begin
            tt = $urandom_range(0, 16'hFFFF);
          end else if (k > 0) begin
            tt = tt + (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 16'h0300));
            if (tt > 16'hFFFF) tt = 16'hFFFF;
          end
          clr = (k == 0) ? ($urandom_range(0, 7) != 0) : ($urandom_range(0, 15) == 0);
          queue_key(clr, TIME_W'(tt), VAL_W'($urandom), VAL_W'($urandom), VAL_W'($urandom),
                    VAL_W'($urandom), PIC_W'($urandom));
        end
        queue_ctl(KIND_START, TIME_W'($urandom));
        nticks = $urandom_range(1, 12);
        avg = tt / nticks + 1;
        for (int k = 0; k < nticks; k++) begin
          if ($urandom_range(0, 11) == 0) d = $urandom_range(0, 16'hFFFF);
          else d = $urandom_range(0, 2 * avg);
          if (d > 16'hFFFF) d = 16'hFFFF;
          queue_ctl(KIND_TICK, TIME_W'(d));
        end
      end else begin
        pending_words.push_back(noise_word());
      end
    end
    total_words = pending_words.size();

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    while (words_taken < total_words || expected_frames.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule

### keyframe_rect_interpolator_top.f
rtl/kri_pkg.sv
rtl/kri_div.sv
rtl/keyframe_rect_interpolator_top.sv
bench/testbench.sv
